// ===== rtl/core/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEPTH  = 128;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = 8;
    localparam int POS_W  = 8;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RD_IDX_M1,
        RD_IDX_P1,
        RD_POS
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_SHIFT,
        WR_VALUE,
        WR_APPEND
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    idx_load_cnt;
        logic    idx_load_pos;
        logic    idx_dec;
        logic    idx_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cap_data;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
        logic idx_gt_pos;
        logic idx_p1_lt_cnt;
    } t_dp_stat;

endpackage

// ===== rtl/core/pal_dpath.sv =====
// ----------------------------------------------------------------------------
// pal_dpath
// Entry memory, fill count, shift index and result registers.
// ----------------------------------------------------------------------------
module pal_dpath import pal_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_ctl,
    input  logic [1:0]               i_cmd,
    input  logic [POS_W-1:0]         i_pos,
    input  logic signed [DATA_W-1:0] i_value,
    output t_dp_stat                 o_stat,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_data_out,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_empty_res,
    output logic                     o_full_res
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_value;
    t_cmd              r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  idx_p1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic              r_done;
    logic [DATA_W-1:0] r_data_out;
    logic [1:0]        r_status;
    logic [CNT_W-1:0]  r_count;
    logic              r_empty;
    logic              r_full;

    assign idx_p1 = r_idx + CNT_W'(1);

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.cnt_inc) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_ctl.cnt_dec) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_comb begin
        case (i_ctl.rd_sel)
            RD_IDX_M1: rd_addr = AW'(r_idx - CNT_W'(1));
            RD_IDX_P1: rd_addr = AW'(idx_p1);
            RD_POS:    rd_addr = AW'(r_pos);
            default:   rd_addr = AW'(r_pos);
        endcase
    end

    always_comb begin
        case (i_ctl.wr_sel)
            WR_SHIFT: begin
                wr_addr = AW'(r_idx);
                wr_data = r_rd_data;
            end
            WR_VALUE: begin
                wr_addr = AW'(r_pos);
                wr_data = r_value;
            end
            WR_APPEND: begin
                wr_addr = AW'(r_cnt);
                wr_data = r_value;
            end
            default: begin
                wr_addr = AW'(r_pos);
                wr_data = r_value;
            end
        endcase
    end

    assign o_stat.cmd           = r_cmd;
    assign o_stat.full          = (r_cnt >= CNT_W'(DEPTH));
    assign o_stat.pos_gt_cnt    = (r_pos > r_cnt);
    assign o_stat.pos_ge_cnt    = (r_pos >= r_cnt);
    assign o_stat.idx_gt_pos    = (r_idx > r_pos);
    assign o_stat.idx_p1_lt_cnt = (idx_p1 < r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_ctl.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_pos   <= i_pos;
            r_value <= i_value;
            r_data  <= '0;
        end else if (i_ctl.cap_data) begin
            r_data <= r_rd_data;
        end
        if (i_ctl.idx_load_cnt) begin
            r_idx <= r_cnt;
        end else if (i_ctl.idx_load_pos) begin
            r_idx <= r_pos;
        end else if (i_ctl.idx_dec) begin
            r_idx <= r_idx - CNT_W'(1);
        end else if (i_ctl.idx_inc) begin
            r_idx <= idx_p1;
        end
        if (i_ctl.finish) begin
            r_data_out <= r_data;
            r_status   <= i_ctl.status;
            r_count    <= n_cnt;
            r_empty    <= (n_cnt == '0);
            r_full     <= (n_cnt == CNT_W'(DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= i_ctl.finish;
        end
    end

    assign o_done      = r_done;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_count     = r_count;
    assign o_empty_res = r_empty;
    assign o_full_res  = r_full;

endmodule

// ===== rtl/core/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Command sequencer: decode, shift loops and result timing.
// ----------------------------------------------------------------------------
module pal_ctrl import pal_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_WR,
        S_DEL_CAP,
        S_DN_RD,
        S_DN_WR,
        S_RD_CAP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    logic   r_fin;
    logic   n_fin;

    always_comb begin
        o_ctl   = '0;
        o_ctl.status = ST_OK;
        o_ctl.rd_sel = RD_POS;
        o_ctl.wr_sel = WR_VALUE;
        n_state = r_state;
        n_fin   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = ST_FULL;
                            n_state      = S_IDLE;
                        end else if (i_stat.pos_gt_cnt) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = ST_BADPOS;
                            n_state      = S_IDLE;
                        end else begin
                            o_ctl.idx_load_cnt = 1'b1;
                            n_state            = S_UP_RD;
                        end
                    end
                    CMD_APPEND: begin
                        o_ctl.finish = 1'b1;
                        n_state      = S_IDLE;
                        if (i_stat.full) begin
                            o_ctl.status = ST_FULL;
                        end else begin
                            o_ctl.wr_en   = 1'b1;
                            o_ctl.wr_sel  = WR_APPEND;
                            o_ctl.cnt_inc = 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = ST_BADPOS;
                            n_state      = S_IDLE;
                        end else begin
                            o_ctl.rd_en        = 1'b1;
                            o_ctl.idx_load_pos = 1'b1;
                            n_state            = S_DEL_CAP;
                        end
                    end
                    default: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_ctl.finish = 1'b1;
                            o_ctl.status = ST_BADPOS;
                            n_state      = S_IDLE;
                        end else begin
                            o_ctl.rd_en = 1'b1;
                            n_state     = S_RD_CAP;
                        end
                    end
                endcase
            end
            S_UP_RD: begin
                if (i_stat.idx_gt_pos) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_IDX_M1;
                    n_state      = S_UP_WR;
                end else begin
                    o_ctl.wr_en   = 1'b1;
                    o_ctl.wr_sel  = WR_VALUE;
                    o_ctl.cnt_inc = 1'b1;
                    o_ctl.finish  = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_UP_WR: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_sel  = WR_SHIFT;
                o_ctl.idx_dec = 1'b1;
                n_state       = S_UP_RD;
            end
            S_DEL_CAP: begin
                o_ctl.cap_data = 1'b1;
                n_state        = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_stat.idx_p1_lt_cnt) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_IDX_P1;
                    n_state      = S_DN_WR;
                end else begin
                    o_ctl.cnt_dec = 1'b1;
                    o_ctl.finish  = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DN_WR: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_sel  = WR_SHIFT;
                o_ctl.idx_inc = 1'b1;
                n_state       = S_DN_RD;
            end
            S_RD_CAP: begin
                o_ctl.cap_data = 1'b1;
                n_fin          = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_fin) begin
            o_ctl.finish = 1'b1;
        end
        n_busy = (n_state != S_IDLE) || n_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_fin   <= n_fin;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== rtl/core/positional_array_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_top
// Bounded ordered list of signed words with insert, append, delete and read.
// ----------------------------------------------------------------------------
//  beat     | signals                            | handshake
//  ---------+------------------------------------+---------------------------
//  command  | i_cmd, i_pos, i_value              | start high, busy low
//  result   | o_data_out, o_status, o_count,     | o_done high for one cycle
//           | o_empty_res, o_full_res            |
//
//  Append and any rejected command finish from the decode state; a read
//  captures the word, then finishes. Insert and delete shift the tail of
//  the list one place, each moved entry through a read state, then a write state.
//  Synchronous active-low reset empties the list; no clearing pass.
//  The result side cannot stall; the next command may start in the o_done cycle.
// ----------------------------------------------------------------------------
module positional_array_list_top import pal_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_cmd,
    input  logic [POS_W-1:0]         i_pos,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_data_out,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_empty_res,
    output logic                     o_full_res
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    pal_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cmd       (i_cmd),
        .i_pos       (i_pos),
        .i_value     (i_value),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_full_res  (o_full_res)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_data_out == '0))
        else $error("rejected command returned nonzero data");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_empty_res == (o_count == '0))
                && (o_full_res == (o_count == CNT_W'(DEPTH))))
        else $error("empty or full flag disagrees with count");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the positional array list against a shadow copy of the list kept
// in the bench. A short table of commands covers the empty list, the word
// extremes, each command and each bad-position rejection. Random runs then
// fill the list to capacity, press on it while full, and drain it again.
// Each o_done result is matched field by field to the oldest pending one.
// ----------------------------------------------------------------------------
module tb;
    import pal_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 300;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
        logic [CNT_W-1:0]         count;
        logic                     empty;
        logic                     full;
    } t_list_res;

    typedef struct packed {
        t_cmd                     cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        logic                     chk;
        logic signed [DATA_W-1:0] data;
        t_status                  status;
        logic [CNT_W-1:0]         count;
    } t_cmd_row;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_FULL,
        PH_DRAIN
    } t_phase;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_cmd;
    logic [POS_W-1:0]         i_pos;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_done;
    logic signed [DATA_W-1:0] o_data_out;
    logic [1:0]               o_status;
    logic [CNT_W-1:0]         o_count;
    logic                     o_empty_res;
    logic                     o_full_res;

    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int                       shadow_held;
    t_list_res                pending_results [$];
    t_cmd_row                 cmd_table [24];
    int                       fail_cnt;
    int                       stall_cycles;
    bit                       beat_taken;
    int                       calm_left;
    t_phase                   phase;
    int                       hold_left;

    positional_array_list_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_pos       (i_pos),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_full_res  (o_full_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_list_res list_apply(t_cmd c, logic [POS_W-1:0] p,
                                             logic signed [DATA_W-1:0] v);
        t_list_res r;
        int        i;
        int        pi;
        pi       = int'(p);
        r.data   = '0;
        r.status = ST_OK;
        case (c)
            CMD_INSERT: begin
                if (shadow_held >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (pi > shadow_held) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = shadow_held; i > pi; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pi] = v;
                    shadow_held++;
                end
            end
            CMD_APPEND: begin
                if (shadow_held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_held] = v;
                    shadow_held++;
                end
            end
            CMD_DELETE: begin
                if (pi >= shadow_held) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data = shadow_words[pi];
                    for (i = pi; i + 1 < shadow_held; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_held--;
                end
            end
            default: begin
                if (pi >= shadow_held)
                    r.status = ST_BADPOS;
                else
                    r.data = shadow_words[pi];
            end
        endcase
        r.count = shadow_held[CNT_W-1:0];
        r.empty = (shadow_held == 0);
        r.full  = (shadow_held == DEPTH);
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 45) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(t_cmd c, logic [POS_W-1:0] p, logic signed [DATA_W-1:0] v,
                             bit typed, t_list_res typed_res);
        int        gap;
        t_list_res r;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= c;
        i_pos   <= p;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        r = list_apply(c, p, v);
        pending_results.push_back(typed ? typed_res : r);
        beat_taken = 1'b1;
    endtask

    task automatic next_random(output t_cmd c, output logic [POS_W-1:0] p,
                               output logic signed [DATA_W-1:0] v);
        int roll;
        roll = $urandom_range(0, 99);
        v    = pick_word();
        p    = POS_W'($urandom_range(0, 255));
        c    = t_cmd'($urandom_range(0, 3));
        case (phase)
            PH_FILL: begin
                if (roll < 50) begin
                    c = CMD_APPEND;
                end else if (roll < 80) begin
                    c = CMD_INSERT;
                    p = POS_W'($urandom_range(0, shadow_held));
                end else if (roll < 95 && shadow_held > 0) begin
                    c = (roll < 90) ? CMD_READ : CMD_DELETE;
                    p = POS_W'($urandom_range(0, shadow_held - 1));
                end
            end
            PH_FULL: begin
                if (hold_left == 0) begin
                    c = CMD_INSERT;
                    p = POS_W'($urandom_range(DEPTH + 1, 255));
                end else if (roll < 30) begin
                    c = CMD_INSERT;
                end else if (roll < 55) begin
                    c = CMD_APPEND;
                end else if (roll < 85) begin
                    c = CMD_READ;
                    p = POS_W'($urandom_range(0, DEPTH - 1));
                end else begin
                    c = CMD_READ;
                    p = POS_W'($urandom_range(DEPTH, 255));
                end
            end
            default: begin
                if (roll < 60 && shadow_held > 0) begin
                    c = CMD_DELETE;
                    p = POS_W'($urandom_range(0, shadow_held - 1));
                end else if (roll < 85 && shadow_held > 0) begin
                    c = CMD_READ;
                    p = POS_W'($urandom_range(0, shadow_held - 1));
                end else if (roll < 95) begin
                    c = (roll < 90) ? CMD_READ : CMD_DELETE;
                    p = POS_W'($urandom_range(shadow_held, 255));
                end else begin
                    c = CMD_APPEND;
                end
            end
        endcase
    endtask

    task automatic advance_phase();
        case (phase)
            PH_FILL: begin
                if (shadow_held == DEPTH) begin
                    phase     = PH_FULL;
                    hold_left = 0;
                end
            end
            PH_FULL: begin
                hold_left++;
                if (hold_left > $urandom_range(4, 10) || shadow_held < DEPTH)
                    phase = PH_DRAIN;
            end
            default: begin
                if (shadow_held == 0)
                    phase = PH_FILL;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_list_res e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: data_out %0d status %0d count %0d",
                       o_data_out, o_status, o_count);
                fail_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (o_data_out !== e.data) begin
                    $error("data_out: expected %0d, got %0d", e.data, o_data_out);
                    fail_cnt++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    fail_cnt++;
                end
                if (o_count !== e.count) begin
                    $error("count: expected %0d, got %0d", e.count, o_count);
                    fail_cnt++;
                end
                if (o_empty_res !== e.empty) begin
                    $error("empty_res: expected %0d, got %0d", e.empty, o_empty_res);
                    fail_cnt++;
                end
                if (o_full_res !== e.full) begin
                    $error("full_res: expected %0d, got %0d", e.full, o_full_res);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (beat_taken || (i_rst_n && o_done)) begin
            stall_cycles <= 0;
        end else if (i_rst_n) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
        beat_taken = 1'b0;
    end

    initial begin
        t_cmd                     c;
        logic [POS_W-1:0]         p;
        logic signed [DATA_W-1:0] v;
        t_list_res                typed_res;
        int                       n;

        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = CMD_INSERT;
        i_pos        = '0;
        i_value      = '0;
        fail_cnt     = 0;
        stall_cycles = 0;
        beat_taken   = 1'b0;
        calm_left    = 0;
        phase        = PH_FILL;
        hold_left    = 0;
        shadow_held  = 0;
        foreach (shadow_words[k]) shadow_words[k] = '0;

        cmd_table = '{
            '{CMD_READ,   8'd0,   32'sh0000_0000, 1'b1, 32'sh0000_0000, ST_BADPOS, 8'd0},
            '{CMD_DELETE, 8'd0,   32'sh0000_0000, 1'b1, 32'sh0000_0000, ST_BADPOS, 8'd0},
            '{CMD_INSERT, 8'd1,   32'sh0000_0005, 1'b1, 32'sh0000_0000, ST_BADPOS, 8'd0},
            '{CMD_INSERT, 8'd0,   32'sh8000_0000, 1'b1, 32'sh0000_0000, ST_OK,     8'd1},
            '{CMD_APPEND, 8'd0,   32'sh7FFF_FFFF, 1'b1, 32'sh0000_0000, ST_OK,     8'd2},
            '{CMD_INSERT, 8'd2,   32'shFFFF_FFFF, 1'b1, 32'sh0000_0000, ST_OK,     8'd3},
            '{CMD_INSERT, 8'd255, 32'sh0000_0001, 1'b1, 32'sh0000_0000, ST_BADPOS, 8'd3},
            '{CMD_READ,   8'd0,   32'sh0000_0000, 1'b1, 32'sh8000_0000, ST_OK,     8'd3},
            '{CMD_READ,   8'd1,   32'sh0000_0000, 1'b1, 32'sh7FFF_FFFF, ST_OK,     8'd3},
            '{CMD_READ,   8'd2,   32'sh0000_0000, 1'b1, 32'shFFFF_FFFF, ST_OK,     8'd3},
            '{CMD_READ,   8'd3,   32'sh0000_0000, 1'b1, 32'sh0000_0000, ST_BADPOS, 8'd3},
            '{CMD_INSERT, 8'd1,   32'sh1234_5678, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_APPEND, 8'd255, 32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_READ,   8'd1,   32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_DELETE, 8'd0,   32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_DELETE, 8'd4,   32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_DELETE, 8'd3,   32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_READ,   8'd128, 32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_DELETE, 8'd0,   32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_DELETE, 8'd1,   32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_DELETE, 8'd0,   32'sh0000_0000, 1'b0, 32'sh0000_0000, ST_OK,     8'd0},
            '{CMD_DELETE, 8'd0,   32'sh0000_0000, 1'b1, 32'sh0000_0000, ST_BADPOS, 8'd0},
            '{CMD_APPEND, 8'd0,   32'shAAAA_AAAA, 1'b1, 32'sh0000_0000, ST_OK,     8'd1},
            '{CMD_INSERT, 8'd0,   32'sh5555_5555, 1'b1, 32'sh0000_0000, ST_OK,     8'd2}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (cmd_table[k]) begin
            typed_res.data   = cmd_table[k].data;
            typed_res.status = cmd_table[k].status;
            typed_res.count  = cmd_table[k].count;
            typed_res.empty  = (cmd_table[k].count == 0);
            typed_res.full   = (cmd_table[k].count == DEPTH);
            send_beat(cmd_table[k].cmd, cmd_table[k].pos, cmd_table[k].value,
                      cmd_table[k].chk, typed_res);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            next_random(c, p, v);
            send_beat(c, p, v, 1'b0, typed_res);
            advance_phase();
        end
        start <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pal_pkg.sv
rtl/core/pal_dpath.sv
rtl/core/pal_ctrl.sv
rtl/core/positional_array_list_top.sv
tb/tb.sv
